// ===== sv/wrms_pkg.sv =====
// ----------------------------------------------------------------------------
// wrms_pkg - windowed rms level meter package
// Widths, constants, controller states and command/status bundles.
// ----------------------------------------------------------------------------
package wrms_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 16;
    localparam int SUM_W      = 46;
    localparam int SQ_W       = 32;
    localparam int LEVEL_W    = 14;
    localparam int IDX_W      = 3;
    localparam int FRAC_W     = 24;
    localparam int MANT_Q     = 30;
    localparam int MANT_W     = MANT_Q + 1;
    localparam int EXP_W      = 6;
    localparam int LOG_W      = EXP_W + FRAC_W;
    localparam int SHCNT_W    = 6;
    localparam int ITER_W     = 5;
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;

    localparam int LOG_ITERS = 24;

    // 1000*log10(2) in q24 is 2^32 + LEVEL_K_LO
    localparam logic [MUL_W-1:0]   LEVEL_K_LO = 32'd755477964;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 14'h3FFF;

    localparam logic [LEN_W-1:0] WINDOW_LEN_RESET = 16'd2000;
    localparam int WINDOWS_PER_REPORT_DEF = 8;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_ZCHK,
        ST_NORM,
        ST_SQ,
        ST_UPD,
        ST_LOGDONE,
        ST_DIFF,
        ST_MULK,
        ST_LVL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load_sample;
        logic accumulate;
        logic level_zero;
        logic log_load;
        logic log_src_len;
        logic norm_shift;
        logic mant_init;
        logic mul_sq;
        logic mant_upd;
        logic save_log_sum;
        logic diff;
        logic mul_level;
        logic level_calc;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic window_end;
        logic sum_small;
        logic norm_top;
        logic iter_last;
        logic src_len;
    } ctrl_sts_t;

endpackage

// ===== sv/wrms_datapath.sv =====
// ----------------------------------------------------------------------------
// wrms_datapath - accumulator, log2 unit and level scaling
// Holds the window state, a shared 32x32 multiplier and the result registers.
// ----------------------------------------------------------------------------
module wrms_datapath #(
    parameter int WINDOWS_PER_REPORT = wrms_pkg::WINDOWS_PER_REPORT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wrms_pkg::ctrl_cmd_t            cmd,
    output wrms_pkg::ctrl_sts_t            sts,
    input  logic                           cfg_we,
    input  logic [wrms_pkg::LEN_W-1:0]     cfg_data,
    input  logic [wrms_pkg::SAMPLE_W-1:0]  sample,
    output logic [wrms_pkg::LEVEL_W-1:0]   level_centi_db,
    output logic [wrms_pkg::IDX_W-1:0]     window_index,
    output logic                           last_window
);

    localparam int WC_W = (WINDOWS_PER_REPORT > 1) ? $clog2(WINDOWS_PER_REPORT) : 1;
    localparam logic [WC_W-1:0] WC_LAST = WC_W'(WINDOWS_PER_REPORT - 1);
    localparam int SUM_W  = wrms_pkg::SUM_W;
    localparam int MANT_W = wrms_pkg::MANT_W;
    localparam int MUL_W  = wrms_pkg::MUL_W;
    localparam int PROD_W = wrms_pkg::PROD_W;
    localparam int LEN_W  = wrms_pkg::LEN_W;
    localparam int SAMPLE_W_P1 = wrms_pkg::SAMPLE_W + 1;

    logic [LEN_W-1:0]                 window_len_reg;
    logic [SUM_W-1:0]                 sum_reg;
    logic [LEN_W-1:0]                 count_reg;
    logic [WC_W-1:0]                  wcnt_reg;
    logic [wrms_pkg::SQ_W-1:0]        sq_reg;
    logic [SUM_W-1:0]                 norm_reg;
    logic [wrms_pkg::SHCNT_W-1:0]     shcnt_reg;
    logic                             src_len_reg;
    logic [MANT_W-1:0]                mant_reg;
    logic [wrms_pkg::EXP_W-1:0]       exp_reg;
    logic [wrms_pkg::FRAC_W-1:0]      frac_reg;
    logic [wrms_pkg::ITER_W-1:0]      iter_reg;
    logic [PROD_W-1:0]                prod_reg;
    logic [wrms_pkg::LOG_W-1:0]       log_sum_reg;
    logic [wrms_pkg::LOG_W-1:0]       d_reg;
    logic [wrms_pkg::LEVEL_W-1:0]     level_reg;
    logic [wrms_pkg::LEVEL_W-1:0]     level_out_reg;
    logic [wrms_pkg::IDX_W-1:0]       index_out_reg;
    logic                             last_out_reg;

    logic [LEN_W-1:0]                 len_eff;
    logic [LEN_W-1:0]                 count_inc;
    logic [SAMPLE_W_P1-1:0]           mag;
    logic [2*SAMPLE_W_P1-1:0]         mag_sq;
    logic [MUL_W-1:0]                 mul_a;
    logic [MUL_W-1:0]                 mul_b;
    logic [PROD_W-1:0]                total;
    logic [LEN_W-1:0]                 lvl_hi;
    logic [WC_W+wrms_pkg::IDX_W-1:0]  wcnt_ext;

    // a zero window length acts as one
    assign len_eff   = (window_len_reg == '0) ? LEN_W'(1) : window_len_reg;
    assign count_inc = count_reg + LEN_W'(1);

    // sample magnitude and its square
    assign mag = sample[wrms_pkg::SAMPLE_W-1]
               ? (SAMPLE_W_P1'(1) << wrms_pkg::SAMPLE_W) - {1'b0, sample}
               : {1'b0, sample};
    assign mag_sq = mag * mag;

    // shared multiplier operands
    always_comb
    begin
        if (cmd.mul_level)
        begin
            mul_a = MUL_W'(d_reg);
            mul_b = wrms_pkg::LEVEL_K_LO;
        end
        else
        begin
            mul_a = MUL_W'(mant_reg);
            mul_b = MUL_W'(mant_reg);
        end
    end

    // d*k + half, with the 2^32 part of k added as a shift
    assign total  = {2'b00, d_reg, 32'h0} + prod_reg + (PROD_W'(1) << 47);
    assign lvl_hi = total[PROD_W-1 -: LEN_W];

    assign wcnt_ext = {{wrms_pkg::IDX_W{1'b0}}, wcnt_reg};

    assign sts.window_end = (count_inc >= len_eff);
    assign sts.sum_small  = (sum_reg <= SUM_W'(len_eff));
    assign sts.norm_top   = norm_reg[SUM_W-1];
    assign sts.iter_last  = (iter_reg == wrms_pkg::ITER_W'(wrms_pkg::LOG_ITERS - 1));
    assign sts.src_len    = src_len_reg;

    // window state; the sum and counters clear at reset, the window length loads its default
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_len_reg <= wrms_pkg::WINDOW_LEN_RESET;
            sum_reg        <= '0;
            count_reg      <= '0;
            wcnt_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
                window_len_reg <= cfg_data;
            if (cmd.accumulate)
            begin
                sum_reg   <= sum_reg + SUM_W'(sq_reg);
                count_reg <= count_inc;
            end
            if (cmd.emit)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                wcnt_reg  <= (wcnt_reg == WC_LAST) ? '0 : wcnt_reg + WC_W'(1);
            end
        end
    end

    // working registers of the log unit and result
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sq_reg <= mag_sq[wrms_pkg::SQ_W-1:0];
        if (cmd.log_load)
        begin
            norm_reg    <= cmd.log_src_len ? SUM_W'(len_eff) : sum_reg;
            shcnt_reg   <= '0;
            src_len_reg <= cmd.log_src_len;
        end
        if (cmd.norm_shift)
        begin
            norm_reg  <= norm_reg << 1;
            shcnt_reg <= shcnt_reg + wrms_pkg::SHCNT_W'(1);
        end
        if (cmd.mant_init)
        begin
            mant_reg <= norm_reg[SUM_W-1 -: MANT_W];
            exp_reg  <= wrms_pkg::EXP_W'(SUM_W - 1) - shcnt_reg;
            frac_reg <= '0;
            iter_reg <= '0;
        end
        if (cmd.mul_sq || cmd.mul_level)
            prod_reg <= mul_a * mul_b;
        if (cmd.mant_upd)
        begin
            // squared mantissa at or above two gives a one bit
            if (prod_reg[2*MANT_W-1])
            begin
                mant_reg <= prod_reg[2*MANT_W-1 -: MANT_W];
                frac_reg <= {frac_reg[wrms_pkg::FRAC_W-2:0], 1'b1};
            end
            else
            begin
                mant_reg <= prod_reg[2*MANT_W-2 -: MANT_W];
                frac_reg <= {frac_reg[wrms_pkg::FRAC_W-2:0], 1'b0};
            end
            iter_reg <= iter_reg + wrms_pkg::ITER_W'(1);
        end
        if (cmd.save_log_sum)
            log_sum_reg <= {exp_reg, frac_reg};
        if (cmd.diff)
            d_reg <= log_sum_reg - {exp_reg, frac_reg};
        if (cmd.level_calc)
            level_reg <= (|lvl_hi[LEN_W-1:wrms_pkg::LEVEL_W])
                       ? wrms_pkg::LEVEL_MAX : lvl_hi[wrms_pkg::LEVEL_W-1:0];
        if (cmd.level_zero)
            level_reg <= '0;
        if (cmd.emit)
        begin
            level_out_reg <= level_reg;
            index_out_reg <= wcnt_ext[wrms_pkg::IDX_W-1:0];
            last_out_reg  <= (wcnt_reg == WC_LAST);
        end
    end

    assign level_centi_db = level_out_reg;
    assign window_index   = index_out_reg;
    assign last_window    = last_out_reg;

endmodule

// ===== sv/wrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// wrms_ctrl - sequencer of the level meter
// Steps accumulation, the two log2 evaluations (or a zero level), scaling and result transfer.
// ----------------------------------------------------------------------------
module wrms_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    output logic                 sample_ready,
    output logic                 level_valid,
    input  logic                 level_ready,
    input  wrms_pkg::ctrl_sts_t  sts,
    output wrms_pkg::ctrl_cmd_t  cmd
);

    wrms_pkg::state_t state_reg;
    wrms_pkg::state_t state_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wrms_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        sample_ready = 1'b0;
        unique case (state_reg)
            wrms_pkg::ST_IDLE:
            begin
                sample_ready = 1'b1;
                if (sample_valid)
                begin
                    cmd.load_sample = 1'b1;
                    state_next      = wrms_pkg::ST_ACC;
                end
            end
            wrms_pkg::ST_ACC:
            begin
                cmd.accumulate = 1'b1;
                state_next = sts.window_end ? wrms_pkg::ST_ZCHK : wrms_pkg::ST_IDLE;
            end
            wrms_pkg::ST_ZCHK:
            begin
                if (sts.sum_small)
                begin
                    cmd.level_zero = 1'b1;
                    state_next     = wrms_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.log_load = 1'b1;
                    state_next   = wrms_pkg::ST_NORM;
                end
            end
            wrms_pkg::ST_NORM:
            begin
                if (sts.norm_top)
                begin
                    cmd.mant_init = 1'b1;
                    state_next    = wrms_pkg::ST_SQ;
                end
                else
                    cmd.norm_shift = 1'b1;
            end
            wrms_pkg::ST_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = wrms_pkg::ST_UPD;
            end
            wrms_pkg::ST_UPD:
            begin
                cmd.mant_upd = 1'b1;
                state_next = sts.iter_last ? wrms_pkg::ST_LOGDONE : wrms_pkg::ST_SQ;
            end
            wrms_pkg::ST_LOGDONE:
            begin
                if (sts.src_len)
                    state_next = wrms_pkg::ST_DIFF;
                else
                begin
                    // log of the sum is done, start on the window length
                    cmd.save_log_sum = 1'b1;
                    cmd.log_load     = 1'b1;
                    cmd.log_src_len  = 1'b1;
                    state_next       = wrms_pkg::ST_NORM;
                end
            end
            wrms_pkg::ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = wrms_pkg::ST_MULK;
            end
            wrms_pkg::ST_MULK:
            begin
                cmd.mul_level = 1'b1;
                state_next    = wrms_pkg::ST_LVL;
            end
            wrms_pkg::ST_LVL:
            begin
                cmd.level_calc = 1'b1;
                state_next     = wrms_pkg::ST_EMIT;
            end
            wrms_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || level_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = wrms_pkg::ST_IDLE;
                end
            end
            default:
                state_next = wrms_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (level_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign level_valid = out_valid_reg;

endmodule

// ===== sv/windowed_rms_decibel_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_decibel_meter - windowed rms level meter in centi-decibels
// Sums squared samples over a window and reports 10*log10 of the mean square.
// ----------------------------------------------------------------------------
// Each sample transfer is captured and squared, then accumulated; samples are
// not taken during the accumulate step. When a window closes with a mean
// square of at most one, a level of zero is emitted directly; otherwise the
// block computes a q24 log2 of the sum and of the window length in one shared
// log unit, each log being a one-bit-per-cycle normalize loop followed by 24
// square-and-test iterations on the shared 32x32 multiplier, and then runs
// the difference, scaling and output steps. Samples are not taken during that
// time. A finished level sits in an output register, so sampling resumes while
// it waits to be taken; a second level only waits if the first is still held.
// window_len is to be written through its own port only while the block is
// idle; the block itself does not enforce this. Zero acts as one.
// level_centi_db is rounded and may be off by one unit.
// ----------------------------------------------------------------------------
module windowed_rms_decibel_meter #(
    parameter int WINDOWS_PER_REPORT = wrms_pkg::WINDOWS_PER_REPORT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // sample channel
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic [wrms_pkg::SAMPLE_W-1:0]  sample,
    // level channel
    output logic                           level_valid,
    input  logic                           level_ready,
    output logic [wrms_pkg::LEVEL_W-1:0]   level_centi_db,
    output logic [wrms_pkg::IDX_W-1:0]     window_index,
    output logic                           last_window,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [wrms_pkg::LEN_W-1:0]     window_len
);

    localparam logic [wrms_pkg::IDX_W-1:0] LAST_IDX =
        wrms_pkg::IDX_W'(WINDOWS_PER_REPORT - 1);

    wrms_pkg::ctrl_cmd_t cmd;
    wrms_pkg::ctrl_sts_t sts;

    // register writes are always taken
    assign cfg_ready = 1'b1;

    // sequencer: owns the handshakes and steps the datapath
    wrms_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .level_valid  (level_valid),
        .level_ready  (level_ready),
        .sts          (sts),
        .cmd          (cmd)
    );

    // datapath: accumulator, log unit, scaling and output payload
    wrms_datapath #(
        .WINDOWS_PER_REPORT (WINDOWS_PER_REPORT)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_valid & cfg_ready),
        .cfg_data       (window_len),
        .sample         (sample),
        .level_centi_db (level_centi_db),
        .window_index   (window_index),
        .last_window    (last_window)
    );

`ifndef SYNTHESIS
    // the flagged window is the last position of a report
    a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        level_valid && last_window |-> window_index == LAST_IDX)
        else $error("last window flagged at a wrong index");

    // a sample transfer is followed by an accumulate cycle
    a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("sample taken during accumulate cycle");
`endif

endmodule
